[rtl/core/homogeneous_point_transform_macros.svh]
// Assertion helpers for the point transform.
// Both expect clk and rst_n in scope.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH

// consequent checked in the same cycle
`define HPT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define HPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hpt_pkg.sv]
`default_nettype none

package hpt_pkg;

    // accumulator holds three exact 64-bit products plus a shifted coefficient
    localparam int ACC_W = 66;
    localparam int PC_W  = 5;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // slots of the result register file
    localparam logic [1:0] RES_X = 2'd0;
    localparam logic [1:0] RES_Y = 2'd1;
    localparam logic [1:0] RES_Z = 2'd2;
    localparam logic [1:0] RES_W = 2'd3;

    // program steps
    localparam logic [PC_W-1:0] ST_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] ST_ROW0     = 5'd1;
    localparam logic [PC_W-1:0] ST_W_STORE  = 5'd21;
    localparam logic [PC_W-1:0] ST_W_TEST   = 5'd22;
    localparam logic [PC_W-1:0] ST_DIV_X    = 5'd23;
    localparam logic [PC_W-1:0] ST_WAIT_X   = 5'd24;
    localparam logic [PC_W-1:0] ST_QUO_X    = 5'd25;
    localparam logic [PC_W-1:0] ST_WAIT_Y   = 5'd26;
    localparam logic [PC_W-1:0] ST_QUO_Y    = 5'd27;
    localparam logic [PC_W-1:0] ST_WAIT_Z   = 5'd28;
    localparam logic [PC_W-1:0] ST_QUO_Z    = 5'd29;
    localparam logic [PC_W-1:0] ST_OUT_WAIT = 5'd30;
    localparam logic [PC_W-1:0] ST_OUT      = 5'd31;

    localparam int ROW_STEPS = 5;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_INIT,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        SRC_X,
        SRC_Y,
        SRC_Z
    } src_sel_t;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_NO_POINT,
        JC_W_ZERO,
        JC_DIV_BUSY,
        JC_OUT_FULL
    } jcond_t;

    typedef struct packed {
        logic            in_rdy;
        acc_op_t         acc_op;
        logic            mul_en;
        logic [3:0]      coef_sel;
        src_sel_t        src_sel;
        logic            res_wr;
        logic [1:0]      res_sel;
        logic            w_test;
        logic            div_start;
        logic [1:0]      div_src;
        logic            quo_wr;
        logic [1:0]      quo_sel;
        logic            out_wr;
        jcond_t          jcond;
        logic [PC_W-1:0] jtarget;
    } ctrl_t;

    typedef struct packed {
        logic        busy;
        logic        sat;
        logic [31:0] quo;
    } div_out_t;

    // one matrix row: load translation, three multiplies, drain the last product;
    // the first step of a row also retires the previous row's clamped sum
    function automatic ctrl_t row_step(input logic [1:0] row, input logic [2:0] phase);
        ctrl_t c;
        c = '0;
        unique case (phase)
            3'd0:
            begin
                c.acc_op   = ACC_INIT;
                c.coef_sel = {2'd3, row};
                c.res_wr   = (row != RES_X);
                c.res_sel  = row - 2'd1;
            end
            3'd1:
            begin
                c.mul_en   = 1'b1;
                c.coef_sel = {2'd0, row};
                c.src_sel  = SRC_X;
            end
            3'd2:
            begin
                c.mul_en   = 1'b1;
                c.coef_sel = {2'd1, row};
                c.src_sel  = SRC_Y;
                c.acc_op   = ACC_ADD;
            end
            3'd3:
            begin
                c.mul_en   = 1'b1;
                c.coef_sel = {2'd2, row};
                c.src_sel  = SRC_Z;
                c.acc_op   = ACC_ADD;
            end
            default:
            begin
                c.acc_op = ACC_ADD;
            end
        endcase
        return c;
    endfunction

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '0;
        for (int r = 0; r < 4; r++)
        begin
            for (int p = 0; p < ROW_STEPS; p++)
            begin
                if (pc == PC_W'(int'(ST_ROW0) + ROW_STEPS * r + p))
                begin
                    c = row_step(2'(r), 3'(p));
                end
            end
        end
        unique case (pc)
            ST_IDLE:
            begin
                c.in_rdy  = 1'b1;
                c.jcond   = JC_NO_POINT;
                c.jtarget = ST_IDLE;
            end
            ST_W_STORE:
            begin
                c.res_wr  = 1'b1;
                c.res_sel = RES_W;
            end
            ST_W_TEST:
            begin
                c.w_test  = 1'b1;
                c.jcond   = JC_W_ZERO;
                c.jtarget = ST_OUT_WAIT;
            end
            ST_DIV_X:
            begin
                c.div_start = 1'b1;
                c.div_src   = RES_X;
            end
            ST_WAIT_X:
            begin
                c.jcond   = JC_DIV_BUSY;
                c.jtarget = ST_WAIT_X;
            end
            ST_QUO_X:
            begin
                c.quo_wr    = 1'b1;
                c.quo_sel   = RES_X;
                c.div_start = 1'b1;
                c.div_src   = RES_Y;
            end
            ST_WAIT_Y:
            begin
                c.jcond   = JC_DIV_BUSY;
                c.jtarget = ST_WAIT_Y;
            end
            ST_QUO_Y:
            begin
                c.quo_wr    = 1'b1;
                c.quo_sel   = RES_Y;
                c.div_start = 1'b1;
                c.div_src   = RES_Z;
            end
            ST_WAIT_Z:
            begin
                c.jcond   = JC_DIV_BUSY;
                c.jtarget = ST_WAIT_Z;
            end
            ST_QUO_Z:
            begin
                c.quo_wr  = 1'b1;
                c.quo_sel = RES_Z;
            end
            ST_OUT_WAIT:
            begin
                c.jcond   = JC_OUT_FULL;
                c.jtarget = ST_OUT_WAIT;
            end
            ST_OUT:
            begin
                c.out_wr  = 1'b1;
                c.jcond   = JC_ALWAYS;
                c.jtarget = ST_IDLE;
            end
            default:
            begin
                // row steps, filled in above
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/hpt_ifs.sv]
`default_nettype none

interface hpt_cmd_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (
        output valid, action, coef_index, coef_value, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, action, coef_index, coef_value, point_x, point_y, point_z,
        output ready
    );
endinterface

interface hpt_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               was_divided;
    logic               saturated;

    modport source (
        output valid, out_x, out_y, out_z, was_divided, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, was_divided, saturated,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/hpt_div.sv]
`default_nettype none

// Restoring divider on magnitudes, two quotient bits per cycle.
// Computes (num << FRAC_BITS) / den truncated toward zero, clamped to 32 bits.
module hpt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output hpt_pkg::div_out_t  res
);

    localparam int DVD_W = 32 + FRAC_BITS;
    // dividend padded with a zero on top to an even width
    localparam int NUM_W = DVD_W + (DVD_W % 2);
    localparam int ITER  = NUM_W / 2;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      d_reg, d_next;
    logic             neg_reg, neg_next;

    logic [NUM_W-1:0] q_step;
    logic [31:0]      r_step;
    logic [31:0]      num_mag;
    logic [31:0]      den_mag;
    logic             over;
    logic [31:0]      q_low;

    assign num_mag = num[31] ? 32'(-num) : 32'(num);
    assign den_mag = den[31] ? 32'(-den) : 32'(den);

    // q_reg shifts the dividend out at the top and the quotient in at the bottom
    always_comb
    begin
        logic [32:0] trial;
        q_step = q_reg;
        r_step = rem_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial  = {r_step, q_step[NUM_W-1]};
            q_step = {q_step[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_step    = 32'(trial - {1'b0, d_reg});
                q_step[0] = 1'b1;
            end
            else
            begin
                r_step = trial[31:0];
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        d_next   = d_reg;
        neg_next = neg_reg;
        priority if (start)
        begin
            cnt_next = CNT_W'(ITER);
            q_next   = NUM_W'({num_mag, {FRAC_BITS{1'b0}}});
            rem_next = '0;
            d_next   = den_mag;
            neg_next = num[31] ^ den[31];
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            q_next   = q_step;
            rem_next = r_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // positive limit is 2^31-1, negative limit is 2^31 in magnitude
    assign over  = (|q_reg[NUM_W-1:32]) || (q_reg[31] && (!neg_reg || (|q_reg[30:0])));
    assign q_low = neg_reg ? 32'(-q_reg[31:0]) : q_reg[31:0];

    assign res.busy = (cnt_reg != '0);
    assign res.sat  = over;
    assign res.quo  = over ? (neg_reg ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX) : q_low;

endmodule

`default_nettype wire

[rtl/core/homogeneous_point_transform.sv]
// Point: a result is queued after the four rows, the w test and three divides; when w is zero
// the divides are skipped; the next point can be taken in the cycle after the result is
// queued, so points are handled one at a time and a full output register holds the flow.
// Most of the time goes to the three divides, at two quotient bits per cycle.
// Coefficient loads are taken one per cycle while idle and produce no result.
// rst_n async, active low: matrix to identity, sequencer to idle, output register empty.
`default_nettype none
`include "homogeneous_point_transform_macros.svh"

module homogeneous_point_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    hpt_cmd_if.sink   cmd,
    hpt_rsp_if.source rsp
);

    localparam int ACC_W = hpt_pkg::ACC_W;
    localparam int PC_W  = hpt_pkg::PC_W;
    localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;

    logic [PC_W-1:0]     pc_reg, pc_next;
    hpt_pkg::ctrl_t      ctrl;
    logic                take_jump;

    logic [31:0]         mat_reg [16];
    logic signed [31:0]  coef;
    logic signed [31:0]  src;
    logic signed [63:0]  mul_full;

    logic signed [31:0]  px_reg, px_next;
    logic signed [31:0]  py_reg, py_next;
    logic signed [31:0]  pz_reg, pz_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] acc_sh;
    logic [ACC_W-32:0]   acc_hi;
    logic                acc_ovf;
    logic signed [31:0]  acc_clamp;

    logic signed [31:0]  res_reg [4];
    logic signed [31:0]  res_next [4];
    logic                sat_reg, sat_next;
    logic                divd_reg, divd_next;

    logic                out_valid_reg, out_valid_next;
    logic signed [31:0]  ox_reg, ox_next;
    logic signed [31:0]  oy_reg, oy_next;
    logic signed [31:0]  oz_reg, oz_next;
    logic                odiv_reg, odiv_next;
    logic                osat_reg, osat_next;

    logic                point_acc;
    logic                load_acc;
    hpt_pkg::div_out_t   div_o;

    assign ctrl      = hpt_pkg::ucode(pc_reg);
    assign cmd.ready = ctrl.in_rdy;
    assign point_acc = cmd.valid && cmd.ready && cmd.action;
    assign load_acc  = cmd.valid && cmd.ready && !cmd.action;

    // coefficient store, column-major, identity after reset
    for (genvar g = 0; g < 16; g++)
    begin : g_mat
        localparam logic [31:0] RST_VAL = ((g % 5) == 0) ? ONE_Q : 32'd0;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mat_reg[g] <= RST_VAL;
            end
            else if (load_acc && (cmd.coef_index == 4'(g)))
            begin
                mat_reg[g] <= cmd.coef_value;
            end
        end
    end

    assign coef = $signed(mat_reg[ctrl.coef_sel]);

    always_comb
    begin
        unique case (ctrl.src_sel)
            hpt_pkg::SRC_X: src = px_reg;
            hpt_pkg::SRC_Y: src = py_reg;
            hpt_pkg::SRC_Z: src = pz_reg;
            default:        src = px_reg;
        endcase
    end

    assign mul_full = coef * src;

    // floor shift then clamp of the finished dot product
    assign acc_sh    = acc_reg >>> FRAC_BITS;
    assign acc_hi    = acc_sh[ACC_W-1:31];
    assign acc_ovf   = !((&acc_hi) || !(|acc_hi));
    assign acc_clamp = acc_ovf ? (acc_sh[ACC_W-1] ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX)
                               : acc_sh[31:0];

    hpt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (res_reg[ctrl.div_src]),
        .den   (res_reg[hpt_pkg::RES_W]),
        .res   (div_o)
    );

    // sequencer
    always_comb
    begin
        unique case (ctrl.jcond)
            hpt_pkg::JC_NONE:     take_jump = 1'b0;
            hpt_pkg::JC_ALWAYS:   take_jump = 1'b1;
            hpt_pkg::JC_NO_POINT: take_jump = !point_acc;
            hpt_pkg::JC_W_ZERO:   take_jump = (res_reg[hpt_pkg::RES_W] == '0);
            hpt_pkg::JC_DIV_BUSY: take_jump = div_o.busy;
            hpt_pkg::JC_OUT_FULL: take_jump = out_valid_reg && !rsp.ready;
            default:              take_jump = 1'b0;
        endcase
        pc_next = take_jump ? ctrl.jtarget : pc_reg + PC_W'(1);
    end

    // datapath
    always_comb
    begin
        px_next   = px_reg;
        py_next   = py_reg;
        pz_next   = pz_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        sat_next  = sat_reg;
        divd_next = divd_reg;

        if (point_acc)
        begin
            px_next  = cmd.point_x;
            py_next  = cmd.point_y;
            pz_next  = cmd.point_z;
            sat_next = 1'b0;
        end

        if (ctrl.mul_en)
        begin
            prod_next = mul_full;
        end

        unique case (ctrl.acc_op)
            hpt_pkg::ACC_INIT: acc_next = ACC_W'(coef) <<< FRAC_BITS;
            hpt_pkg::ACC_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
            default:           acc_next = acc_reg;
        endcase

        if (ctrl.res_wr)
        begin
            res_next[ctrl.res_sel] = acc_clamp;
            sat_next = sat_reg || acc_ovf;
        end

        if (ctrl.quo_wr)
        begin
            res_next[ctrl.quo_sel] = $signed(div_o.quo);
            sat_next = sat_reg || div_o.sat;
        end

        if (ctrl.w_test)
        begin
            divd_next = (res_reg[hpt_pkg::RES_W] != '0);
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        odiv_next      = odiv_reg;
        osat_next      = osat_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.out_wr)
        begin
            out_valid_next = 1'b1;
            ox_next        = res_reg[hpt_pkg::RES_X];
            oy_next        = res_reg[hpt_pkg::RES_Y];
            oz_next        = res_reg[hpt_pkg::RES_Z];
            odiv_next      = divd_reg;
            osat_next      = sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= hpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        sat_reg  <= sat_next;
        divd_reg <= divd_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        odiv_reg <= odiv_next;
        osat_reg <= osat_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.out_x       = ox_reg;
    assign rsp.out_y       = oy_reg;
    assign rsp.out_z       = oz_reg;
    assign rsp.was_divided = odiv_reg;
    assign rsp.saturated   = osat_reg;

    `HPT_ASSERT_SAME(a_out_slot_free, ctrl.out_wr, !out_valid_reg, "result overwrites pending transaction")
    `HPT_ASSERT_NEXT(a_out_follows_wr, ctrl.out_wr, out_valid_reg, "result write lost")
    `HPT_ASSERT_SAME(a_div_idle_use, ctrl.div_start || ctrl.quo_wr, !div_o.busy, "divider used while busy")
    `HPT_ASSERT_NEXT(a_div_runs, ctrl.div_start, div_o.busy, "divider did not start")

endmodule

`default_nettype wire
